// ----- rtl/core/base64_stream_decoder_core_defines.svh -----
// Assertion macros shared by the decoder RTL.
`ifndef BASE64_STREAM_DECODER_CORE_DEFINES_SVH
`define BASE64_STREAM_DECODER_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
// Property must hold at every clock edge outside reset.
`define B64SD_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("b64sd assertion failed");
// Expression must never be true outside reset.
`define B64SD_ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("b64sd forbidden condition seen");
`else
`define B64SD_ASSERT(lbl, clk, rst_n, prop)
`define B64SD_ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif

`endif

// ----- rtl/core/b64sd_pkg.sv -----
package b64sd_pkg;

    localparam int COUNT_BITS = 16;
    localparam int OUT_COUNT_BITS = 16;
    localparam int CMP_BITS = ((COUNT_BITS > 16) ? COUNT_BITS : 16) + 2;

    localparam int QDEPTH = 8;
    localparam int QPTR_BITS = $clog2(QDEPTH);
    localparam int QCNT_BITS = $clog2(QDEPTH + 1);

    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_PAD  = 2'd1,
        ST_OVF  = 2'd2,
        ST_PART = 2'd3
    } status_t;

    typedef struct packed {
        logic       skip;
        logic       pad;
        logic [5:0] val;
    } sym_t;

    // One queue entry: all results caused by one accepted item.
    typedef struct packed {
        logic [2:0][7:0]         data;
        logic [COUNT_BITS-1:0]   base;
        logic [1:0]              nbytes;
        logic                    has_status;
        status_t                 status;
    } cmd_t;

    function automatic sym_t map_char(input logic [7:0] ch);
        sym_t       s;
        logic [6:0] c;
        c = ch[6:0];
        s.skip = 1'b0;
        s.pad  = 1'b0;
        s.val  = 6'd0;
        if (c >= 7'h41 && c <= 7'h5A) begin
            s.val = 6'(c - 7'h41);
        end else if (c >= 7'h61 && c <= 7'h7A) begin
            s.val = 6'(c - 7'd71);
        end else if (c >= 7'h30 && c <= 7'h39) begin
            s.val = 6'(c + 7'd4);
        end else if (c == 7'h2B) begin
            s.val = 6'd62;
        end else if (c == 7'h2F) begin
            s.val = 6'd63;
        end else if (c == 7'h3D) begin
            s.pad = 1'b1;
        end else begin
            s.skip = 1'b1;
        end
        return s;
    endfunction

    // Fit the internal counter to the 16-bit result field.
    function automatic logic [OUT_COUNT_BITS-1:0] to_out_count(
        input logic [COUNT_BITS-1:0] c);
        logic [COUNT_BITS+OUT_COUNT_BITS-1:0] t;
        t = {{OUT_COUNT_BITS{1'b0}}, c};
        return t[OUT_COUNT_BITS-1:0];
    endfunction

endpackage

// ----- rtl/core/b64sd_front.sv -----
`include "base64_stream_decoder_core_defines.svh"

module b64sd_front
    import b64sd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  in_char,
    input  logic        last_char,
    input  logic        q_full,
    output logic        q_push,
    output cmd_t        q_cmd
);

    logic [15:0]           max_len_reg;
    logic [23:0]           acc_reg, acc_next;
    logic [1:0]            nsym_reg, nsym_next;
    logic [1:0]            pads_reg, pads_next;
    status_t               err_reg, err_next;
    logic [COUNT_BITS-1:0] cnt_reg, cnt_next;

    sym_t        sym;
    logic        fire;
    logic        sym_ok;
    logic [23:0] acc_shift;
    logic [1:0]  nwant;
    logic [1:0]  nemit;
    logic [2:0]  room;
    status_t     status_fin;

    assign in_ready = !q_full;
    assign fire     = in_valid && in_ready;

    // room[i]: byte i of this group still fits under both limits
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            room[i] = ((CMP_BITS'(cnt_reg) + CMP_BITS'(i)) < CMP_BITS'(max_len_reg)) &&
                      ((CMP_BITS'(cnt_reg) + CMP_BITS'(i)) <
                       CMP_BITS'({COUNT_BITS{1'b1}}));
        end
    end

    always_comb
    begin
        sym       = map_char(in_char);
        acc_next  = acc_reg;
        nsym_next = nsym_reg;
        pads_next = pads_reg;
        err_next  = err_reg;
        sym_ok    = 1'b0;
        nwant     = 2'd0;
        nemit     = 2'd0;
        acc_shift = {acc_reg[17:0], sym.val};

        if (err_reg == ST_OK && !sym.skip)
        begin
            sym_ok = 1'b1;
            if (sym.pad)
            begin
                if (pads_reg == 2'd0)
                begin
                    err_next = ST_PAD;
                    sym_ok   = 1'b0;
                end
                else
                begin
                    pads_next = pads_reg - 2'd1;
                end
            end
            else if (pads_reg != 2'd3)
            begin
                err_next = ST_PAD;
                sym_ok   = 1'b0;
            end

            if (sym_ok)
            begin
                if (nsym_reg == 2'd3)
                begin
                    nwant     = (pads_next == 2'd3) ? 2'd3 :
                                (pads_next == 2'd2) ? 2'd2 : 2'd1;
                    acc_next  = 24'd0;
                    nsym_next = 2'd0;
                end
                else
                begin
                    acc_next  = acc_shift;
                    nsym_next = nsym_reg + 2'd1;
                end
            end
        end

        if (nwant != 2'd0)
        begin
            if (!room[0])
                nemit = 2'd0;
            else if (nwant < 2'd2 || !room[1])
                nemit = 2'd1;
            else if (nwant < 2'd3 || !room[2])
                nemit = 2'd2;
            else
                nemit = 2'd3;
            if (nemit < nwant)
                err_next = ST_OVF;
        end

        cnt_next   = cnt_reg + COUNT_BITS'(nemit);
        status_fin = (err_next == ST_OK && nsym_next != 2'd0) ? ST_PART : err_next;

        q_cmd.data       = {acc_shift[7:0], acc_shift[15:8], acc_shift[23:16]};
        q_cmd.base       = cnt_reg;
        q_cmd.nbytes     = nemit;
        q_cmd.has_status = last_char;
        q_cmd.status     = status_fin;
    end

    assign q_push = fire && (nemit != 2'd0 || last_char);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg <= 16'hFFFF;
            acc_reg     <= 24'd0;
            nsym_reg    <= 2'd0;
            pads_reg    <= 2'd3;
            err_reg     <= ST_OK;
            cnt_reg     <= '0;
        end
        else
        begin
            if (cfg_wr_en)
                max_len_reg <= cfg_wr_data;
            if (fire)
            begin
                if (last_char)
                begin
                    acc_reg  <= 24'd0;
                    nsym_reg <= 2'd0;
                    pads_reg <= 2'd3;
                    err_reg  <= ST_OK;
                    cnt_reg  <= '0;
                end
                else
                begin
                    acc_reg  <= acc_next;
                    nsym_reg <= nsym_next;
                    pads_reg <= pads_next;
                    err_reg  <= err_next;
                    cnt_reg  <= cnt_next;
                end
            end
        end
    end

    // a latched error holds until the final item of the text
    `B64SD_ASSERT(a_err_sticky, clk, rst_n,
        (err_reg != ST_OK && !(fire && last_char)) |=> (err_reg == $past(err_reg)))

endmodule

// ----- rtl/core/b64sd_queue.sv -----
`include "base64_stream_decoder_core_defines.svh"

module b64sd_queue
    import b64sd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t din,
    input  logic pop,
    output cmd_t dout,
    output logic full,
    output logic empty
);

    cmd_t                 mem_reg [QDEPTH];
    logic [QPTR_BITS-1:0] wr_ptr_reg;
    logic [QPTR_BITS-1:0] rd_ptr_reg;
    logic [QCNT_BITS-1:0] cnt_reg;

    assign full  = (cnt_reg == QCNT_BITS'(QDEPTH));
    assign empty = (cnt_reg == '0);
    assign dout  = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= din;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + QPTR_BITS'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + QPTR_BITS'(1);
            if (push && !pop)
                cnt_reg <= cnt_reg + QCNT_BITS'(1);
            else if (pop && !push)
                cnt_reg <= cnt_reg - QCNT_BITS'(1);
        end
    end

    `B64SD_ASSERT_NEVER(a_q_overrun, clk, rst_n, push && full)
    `B64SD_ASSERT_NEVER(a_q_underrun, clk, rst_n, pop && empty)

endmodule

// ----- rtl/core/b64sd_back.sv -----
`include "base64_stream_decoder_core_defines.svh"

module b64sd_back
    import b64sd_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      q_empty,
    input  cmd_t                      q_head,
    output logic                      q_pop,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic                      kind,
    output logic [7:0]                out_byte,
    output logic [1:0]                status,
    output logic [OUT_COUNT_BITS-1:0] out_count,
    output logic                      run_last
);

    logic [1:0]                idx_reg;
    logic                      valid_reg;
    logic                      kind_reg;
    logic [7:0]                byte_reg;
    logic [1:0]                status_reg;
    logic [OUT_COUNT_BITS-1:0] count_reg;
    logic                      last_reg;

    logic                      load;
    logic                      is_status;
    logic                      is_final;
    logic [2:0]                total;
    logic [7:0]                sel_byte;
    logic [COUNT_BITS-1:0]     cnt_sel;

    assign load      = !valid_reg || out_ready;
    assign total     = {1'b0, q_head.nbytes} + {2'b00, q_head.has_status};
    assign is_status = (idx_reg == q_head.nbytes);
    assign is_final  = (({1'b0, idx_reg} + 3'd1) == total);
    assign q_pop     = load && !q_empty && is_final;

    always_comb
    begin
        case (idx_reg)
            2'd0:    sel_byte = q_head.data[0];
            2'd1:    sel_byte = q_head.data[1];
            2'd2:    sel_byte = q_head.data[2];
            default: sel_byte = 8'd0;
        endcase
        cnt_sel = q_head.base +
                  (is_status ? COUNT_BITS'(idx_reg) : COUNT_BITS'(idx_reg) + COUNT_BITS'(1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end
        else if (load)
        begin
            valid_reg <= !q_empty;
            if (!q_empty)
                idx_reg <= is_final ? 2'd0 : idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && !q_empty)
        begin
            kind_reg   <= is_status ? KIND_STATUS : KIND_DATA;
            byte_reg   <= is_status ? 8'd0 : sel_byte;
            status_reg <= is_status ? q_head.status : ST_OK;
            count_reg  <= to_out_count(cnt_sel);
            last_reg   <= is_final;
        end
    end

    assign out_valid = valid_reg;
    assign kind      = kind_reg;
    assign out_byte  = byte_reg;
    assign status    = status_reg;
    assign out_count = count_reg;
    assign run_last  = last_reg;

    // the status result always closes the run of its item
    `B64SD_ASSERT(a_status_last, clk, rst_n,
        (valid_reg && kind_reg == KIND_STATUS) |-> last_reg)

endmodule

// ----- rtl/core/base64_stream_decoder_core.sv -----
// Streaming base64 decoder. One text character is taken per item (low 7 bits
// used, last_char marks the end of the text); characters outside the base64
// alphabet are skipped and '=' is padding. Each completed group of four
// symbols yields up to three data results (kind 0), and the final item adds a
// status result (kind 1) with the total byte count; run_last flags the last
// result of each item. Rate: one character per cycle, accepted while the
// 8-entry command queue between the decode front and the result back has
// room. The back delivers one result per cycle while out_ready holds, through
// a single output register. A text never yields more results than it has
// characters, so with the output ready the queue does not fill and the input
// never stalls; only output back-pressure can stall it. An accepted item is
// queued, and its first result is then loaded into the output register once
// the results ahead of it are taken. Errors (bad padding, overflow of
// max_out_len) are latched, suppress later bytes, and are reported in the
// final status, as is an incomplete final group; the stream state then
// clears. max_out_len must be written only while the block is idle.
module base64_stream_decoder_core
    import b64sd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  in_char,
    input  logic        last_char,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        kind,
    output logic [7:0]  out_byte,
    output logic [1:0]  status,
    output logic [15:0] out_count,
    output logic        run_last
);

    // front -> queue
    logic q_push;
    cmd_t q_cmd;
    logic q_full;
    // queue -> back
    cmd_t q_head;
    logic q_empty;
    logic q_pop;

    // classify characters, track group/pad/error state, build one command
    b64sd_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_char     (in_char),
        .last_char   (last_char),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_cmd       (q_cmd)
    );

    // decouples decode from result delivery
    b64sd_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .din   (q_cmd),
        .pop   (q_pop),
        .dout  (q_head),
        .full  (q_full),
        .empty (q_empty)
    );

    // serializes each command into data bytes and the optional status
    b64sd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .kind      (kind),
        .out_byte  (out_byte),
        .status    (status),
        .out_count (out_count),
        .run_last  (run_last)
    );

endmodule
